// ===== design/c2u_pkg.sv =====
// Shared constants, types and the month table for the calendar to epoch-seconds converter.
package c2u_pkg;

  // Field widths
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int MDAY_W  = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int SECS_W  = 34;

  // Internal widths
  localparam int YDAY_W  = 9;   // day of year before leap adjust, up to 365
  localparam int PROD_W  = 25;  // year times reciprocal of 100
  localparam int Q100_W  = 6;   // year / 100, up to 40
  localparam int LEAPS_W = 11;  // leap years through year-1, up to 993
  localparam int YDAYS_W = 20;  // 365-day years since the epoch, up to 775625
  localparam int DAYS_W  = 21;  // signed whole days, -1 .. about 776506
  localparam int TOD_W   = 17;  // time of day in seconds, up to 115443
  localparam int TOT_W   = 38;  // signed total before clamping

  // Calendar constants
  localparam logic [YEAR_W-1:0]  EPOCH_YEAR         = 12'd1970;
  localparam logic [LEAPS_W-1:0] LEAPS_BEFORE_EPOCH = 11'd477;  // leap years in 1..1969
  localparam int DAYS_PER_YEAR = 365;
  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;

  // floor(y / 100) = (y * RECIP_100) >> RECIP_SHIFT, exact for any 12-bit year
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;

  // Load enables for the three day-count stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // Days before the first of each month in a common year, index 0 is January
  function automatic logic [YDAY_W-1:0] days_before_month(input logic [3:0] idx);
    logic [YDAY_W-1:0] d;
    unique case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    return d;
  endfunction

endpackage

// ===== design/c2u_days.sv =====
// Three-stage date to day-count pipeline: month table, leap rules and year weighting.
module c2u_days
  import c2u_pkg::*;
(
  input  logic                       clk,
  input  stage_en_t                  en,            // per-stage load enables
  input  logic [YEAR_W-1:0]          year,
  input  logic [MONTH_W-1:0]         month,
  input  logic [MDAY_W-1:0]          day_of_month,
  output logic signed [DAYS_W-1:0]   days           // whole days since the epoch
);

  // Stage 1: month lookup, reciprocal products for the century counts
  logic [3:0]          month_idx;
  logic [YEAR_W-1:0]   year_m1;
  logic [YDAY_W-1:0]   yday_next;
  logic [PROD_W-1:0]   prod_y_next;
  logic [PROD_W-1:0]   prod_m1_next;

  logic [YEAR_W-1:0]   s1_year;
  logic [YEAR_W-1:0]   s1_year_m1;
  logic [PROD_W-1:0]   s1_prod_y;
  logic [PROD_W-1:0]   s1_prod_m1;
  logic [YDAY_W-1:0]   s1_yday;
  logic                s1_march;

  always_comb begin
    if (month == '0) begin
      month_idx = 4'd0;
    end else if (month > 4'd12) begin
      month_idx = 4'd11;
    end else begin
      month_idx = month - 4'd1;
    end
  end

  assign year_m1      = year - YEAR_W'(1);
  assign yday_next    = days_before_month(month_idx) + YDAY_W'(day_of_month);
  assign prod_y_next  = PROD_W'(year) * PROD_W'(RECIP_100);
  assign prod_m1_next = PROD_W'(year_m1) * PROD_W'(RECIP_100);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      s1_year    <= year;
      s1_year_m1 <= year_m1;
      s1_prod_y  <= prod_y_next;
      s1_prod_m1 <= prod_m1_next;
      s1_yday    <= yday_next;
      s1_march   <= (month >= 4'd3);
    end
  end

  // Stage 2: leap flag of this year, leap count before it, 365-day years
  logic [Q100_W-1:0]        q_y;
  logic [Q100_W-1:0]        q_m1;
  logic [YEAR_W-1:0]        q_y_x100;
  logic                     leap;
  logic [LEAPS_W-1:0]       leaps_m1;
  logic [YEAR_W-1:0]        year_off;
  logic [YDAYS_W-1:0]       year_days_next;

  logic [YDAYS_W-1:0]       s2_year_days;
  logic signed [LEAPS_W:0]  s2_leaps_net;
  logic [YDAY_W-1:0]        s2_yday;
  logic                     s2_leap_add;

  assign q_y      = s1_prod_y[RECIP_SHIFT +: Q100_W];
  assign q_m1     = s1_prod_m1[RECIP_SHIFT +: Q100_W];
  assign q_y_x100 = YEAR_W'(q_y) * YEAR_W'(100);
  assign leap     = (s1_year[1:0] == 2'b00) && ((q_y_x100 != s1_year) || (q_y[1:0] == 2'b00));
  assign leaps_m1 = LEAPS_W'(s1_year_m1[YEAR_W-1:2]) - LEAPS_W'(q_m1)
                  + LEAPS_W'(q_m1[Q100_W-1:2]);
  assign year_off = s1_year - EPOCH_YEAR;
  assign year_days_next = YDAYS_W'(year_off) * YDAYS_W'(DAYS_PER_YEAR);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      s2_year_days <= year_days_next;
      s2_leaps_net <= $signed({1'b0, leaps_m1}) - $signed({1'b0, LEAPS_BEFORE_EPOCH});
      s2_yday      <= s1_yday;
      s2_leap_add  <= s1_march & leap;
    end
  end

  // Stage 3: sum to whole days; day zero of the month counts back one
  always_ff @(posedge clk) begin
    if (en.s3) begin
      days <= $signed(DAYS_W'(s2_year_days) + DAYS_W'(s2_leaps_net) + DAYS_W'(s2_yday)
                      + DAYS_W'(s2_leap_add) - DAYS_W'(1));
    end
  end

endmodule

// ===== design/calendar_to_unix_seconds_core.sv =====
// Top level: stream wrapper and five-stage pipeline from calendar date to epoch seconds.
//
//  channel   dir  transaction payload
//  s_axis    in   year, month, day_of_month, hour, minute, second
//  m_axis    out  unix_seconds
//
// Five register stages; one date enters every cycle unless a stall reaches the
// input. Stages: month table and reciprocal products, leap rules, day sum, one
// 21x17 multiply by seconds per day, final add and clamp.
// rst clears the valid bits only. A stall holds each stage whose successor
// is full; bubbles are squeezed out.
module calendar_to_unix_seconds_core
  import c2u_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
  // [31:26] minute, [37:32] second, [39:38] zero
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [33:0] unix_seconds, [39:34] zero
  output logic [39:0] m_axis_tdata
);

  // Input field unpacking
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [MDAY_W-1:0]  day_of_month;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SEC_W-1:0]   second;

  assign year         = s_axis_tdata[11:0];
  assign month        = s_axis_tdata[15:12];
  assign day_of_month = s_axis_tdata[20:16];
  assign hour         = s_axis_tdata[25:21];
  assign minute       = s_axis_tdata[31:26];
  assign second       = s_axis_tdata[37:32];

  // Valid bits and per-stage enables; a stage loads when empty or draining
  logic      v1, v2, v3, v4, v5;
  logic      en1, en2, en3, en4, en5;
  stage_en_t days_en;

  assign en5 = !v5 || m_axis_tready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_axis_tready = en1;
  assign days_en = '{s1: en1, s2: en2, s3: en3};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= s_axis_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Day count pipeline, stages one to three
  logic signed [DAYS_W-1:0] days;

  c2u_days u_days (
    .clk          (clk),
    .en           (days_en),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .days         (days)
  );

  // Time of day and pre-epoch flag, carried alongside the day count
  logic [TOD_W-1:0] tod_next;
  logic [TOD_W-1:0] t1_tod, t2_tod, t3_tod, t4_tod;
  logic             t1_zero, t2_zero, t3_zero, t4_zero;

  assign tod_next = TOD_W'(hour) * TOD_W'(SECS_PER_HOUR) + TOD_W'(minute) * TOD_W'(SECS_PER_MIN)
                  + TOD_W'(second);

  always_ff @(posedge clk) begin
    if (en1) begin
      t1_tod  <= tod_next;
      t1_zero <= (year < EPOCH_YEAR);
    end
    if (en2) begin
      t2_tod  <= t1_tod;
      t2_zero <= t1_zero;
    end
    if (en3) begin
      t3_tod  <= t2_tod;
      t3_zero <= t2_zero;
    end
  end

  // Stage 4: days times seconds per day
  logic signed [TOT_W-1:0] s4_day_secs;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_day_secs <= TOT_W'(days) * $signed(TOT_W'(SECS_PER_DAY));
      t4_tod      <= t3_tod;
      t4_zero     <= t3_zero;
    end
  end

  // Stage 5: add time of day, clamp to the output range
  logic signed [TOT_W-1:0] total;
  logic [SECS_W-1:0]       unix_seconds;
  logic [SECS_W-1:0]       secs_next;

  assign total = s4_day_secs + $signed(TOT_W'(t4_tod));

  always_comb begin
    if (t4_zero || total[TOT_W-1]) begin
      secs_next = '0;
    end else if (total[TOT_W-1:SECS_W] != '0) begin
      secs_next = '1;
    end else begin
      secs_next = total[SECS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      unix_seconds <= secs_next;
    end
  end

  assign m_axis_tvalid = v5;
  assign m_axis_tdata  = {6'b0, unix_seconds};

endmodule

// ===== tb/tb_top.sv =====
// Self-checking stream testbench for the calendar date to epoch seconds converter.
module tb_top
  import c2u_pkg::*;
;

  localparam int  EPOCH_YEAR    = 1970;
  localparam int  DAYS_IN_YEAR  = 365;
  localparam int  SECS_IN_DAY   = 86400;
  localparam int  SECS_IN_HOUR  = 3600;
  localparam int  SECS_IN_MIN   = 60;
  localparam int  RANDOM_DATES  = 1430;
  localparam int  IDLE_PCT      = 35;
  localparam int  QUIET_LO      = 400;   // no idling on either side in this window
  localparam int  QUIET_HI      = 700;
  localparam int  SECOND_DRAIN  = 1000;  // sender waits for all results here
  localparam int  TAIL_CYCLES   = 20;
  localparam int  STALL_LIMIT   = 2000;
  localparam longint SECS_MAX   = 64'h3_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
  // [31:26] minute, [37:32] second, [39:38] zero
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [33:0] unix_seconds, [39:34] zero
  logic [39:0] m_axis_tdata;

  logic [39:0]       pending_dates[$];
  logic [SECS_W-1:0] expected_secs[$];
  int n_loaded      = 0;
  int n_dates_in    = 0;
  int n_results_out = 0;
  int n_directed    = 0;
  int n_total       = 0;
  int n_errors      = 0;

  wire no_idle = (n_dates_in >= QUIET_LO) && (n_dates_in < QUIET_HI);

  calendar_to_unix_seconds_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Pack one calendar date into the input word; each field keeps its low bits
  function automatic logic [39:0] date_word(input int y, input int m, input int d,
                                            input int h, input int mi, input int s);
    return {2'b00, SEC_W'(s), MIN_W'(mi), HOUR_W'(h), MDAY_W'(d), MONTH_W'(m), YEAR_W'(y)};
  endfunction

  // Seconds since the epoch for one input word, with clamping at both ends
  function automatic logic [SECS_W-1:0] epoch_seconds(input logic [39:0] w);
    longint yr, mo, md, hr, mi, se, yday, ylast, days, total;
    yr = longint'(w[11:0]);
    mo = longint'(w[15:12]);
    md = longint'(w[20:16]);
    hr = longint'(w[25:21]);
    mi = longint'(w[31:26]);
    se = longint'(w[37:32]);
    if (yr < EPOCH_YEAR) return '0;
    if (mo < 1) mo = 1;
    if (mo > 12) mo = 12;
    case (mo)
      1:  yday = 0;
      2:  yday = 31;
      3:  yday = 59;
      4:  yday = 90;
      5:  yday = 120;
      6:  yday = 151;
      7:  yday = 181;
      8:  yday = 212;
      9:  yday = 243;
      10: yday = 273;
      11: yday = 304;
      default: yday = 334;
    endcase
    yday = yday + md - 1;
    // Feb 29 shifts everything from March on in a leap year
    if (mo >= 3 && (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0)))
      yday = yday + 1;
    // leap years strictly before this year, minus those before the epoch
    ylast = yr - 1;
    days = (yr - EPOCH_YEAR) * DAYS_IN_YEAR
         + (ylast / 4 - ylast / 100 + ylast / 400)
         - ((EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100 + (EPOCH_YEAR - 1) / 400)
         + yday;
    total = days * SECS_IN_DAY + hr * SECS_IN_HOUR + mi * SECS_IN_MIN + se;
    if (total < 0) total = 0;
    if (total > SECS_MAX) total = SECS_MAX;
    return total[SECS_W-1:0];
  endfunction

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Input driver: one transaction per handshake, random idles, drain pauses
  always @(posedge clk) begin : drive_dates
    int  acc_now;
    bit  hold;
    bit  go;
    acc_now = n_dates_in;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_secs.push_back(epoch_seconds(s_axis_tdata));
        acc_now = acc_now + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        hold = (n_loaded == n_directed || n_loaded == SECOND_DRAIN) &&
               (acc_now != n_results_out);
        go = (pending_dates.size() > 0) && !hold &&
             (no_idle || ($urandom_range(99) >= IDLE_PCT));
        if (go) begin
          s_axis_tdata  <= pending_dates.pop_front();
          s_axis_tvalid <= 1'b1;
          n_loaded      <= n_loaded + 1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      n_dates_in <= acc_now;
    end
  end

  // Output monitor: random backpressure, in-order compare
  always @(posedge clk) begin : check_results
    logic [SECS_W-1:0] want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_secs.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0d",
                   $time, m_axis_tdata[SECS_W-1:0]);
          n_errors = n_errors + 1;
        end else begin
          want = expected_secs.pop_front();
          if (m_axis_tdata[SECS_W-1:0] !== want) begin
            $display("%0t: unix_seconds mismatch, expected %0d, got %0d",
                     $time, want, m_axis_tdata[SECS_W-1:0]);
            n_errors = n_errors + 1;
          end
        end
        n_results_out <= n_results_out + 1;
      end
    end
  end

  // Watchdog on cycles without any transaction
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles = stall_cycles + 1;
    end
    $display("Verification failed");
    $finish;
  end

  // Stimulus and end of run
  initial begin : stimulus
    int pick;
    int yr_sel;
    // epoch start, day zero at the epoch, years before the epoch
    pending_dates.push_back(date_word(1970, 1, 1, 0, 0, 0));
    pending_dates.push_back(date_word(1970, 1, 0, 0, 0, 0));
    pending_dates.push_back(date_word(1970, 1, 0, 23, 59, 59));
    pending_dates.push_back(date_word(1969, 6, 15, 12, 30, 30));
    pending_dates.push_back(date_word(0, 0, 0, 0, 0, 0));
    // top of range and overflow clamp
    pending_dates.push_back(date_word(2399, 12, 31, 23, 59, 59));
    pending_dates.push_back(date_word(4095, 15, 31, 31, 63, 63));
    pending_dates.push_back(date_word(2600, 1, 1, 0, 0, 0));
    // month zero and months above twelve
    pending_dates.push_back(date_word(2000, 0, 10, 8, 20, 40));
    pending_dates.push_back(date_word(2021, 13, 1, 0, 0, 0));
    pending_dates.push_back(date_word(2021, 15, 31, 23, 59, 59));
    // leap rules: plain leap, 400-year century, 100-year century
    pending_dates.push_back(date_word(2024, 2, 29, 12, 0, 0));
    pending_dates.push_back(date_word(2024, 3, 1, 0, 0, 0));
    pending_dates.push_back(date_word(2023, 3, 1, 0, 0, 0));
    pending_dates.push_back(date_word(2000, 2, 29, 23, 59, 59));
    pending_dates.push_back(date_word(2000, 3, 1, 0, 0, 0));
    pending_dates.push_back(date_word(2100, 2, 28, 23, 59, 59));
    pending_dates.push_back(date_word(2100, 3, 1, 0, 0, 0));
    pending_dates.push_back(date_word(1972, 12, 31, 23, 59, 59));
    // 32-bit rollover points, day zero mid-year, time fields that carry
    pending_dates.push_back(date_word(2038, 1, 19, 3, 14, 7));
    pending_dates.push_back(date_word(2106, 2, 7, 6, 28, 15));
    pending_dates.push_back(date_word(2020, 6, 0, 0, 0, 0));
    pending_dates.push_back(date_word(2020, 1, 31, 31, 63, 63));
    n_directed = pending_dates.size();

    // random: mostly valid dates, some around leap boundaries, some raw bits
    repeat (RANDOM_DATES) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        pending_dates.push_back(date_word($urandom_range(2399, 1970), $urandom_range(12, 1),
                                          $urandom_range(31, 1), $urandom_range(23, 0),
                                          $urandom_range(59, 0), $urandom_range(59, 0)));
      end else if (pick < 85) begin
        case ($urandom_range(3))
          0:       yr_sel = 100 * $urandom_range(23, 20);
          1:       yr_sel = $urandom_range(2399, 2392);
          2:       yr_sel = $urandom_range(1975, 1970);
          default: yr_sel = 4 * $urandom_range(599, 493);
        endcase
        pending_dates.push_back(date_word(yr_sel, $urandom_range(3, 2), $urandom_range(29, 28),
                                          $urandom_range(23, 0), $urandom_range(59, 0),
                                          $urandom_range(59, 0)));
      end else begin
        pending_dates.push_back(date_word($urandom(), $urandom(), $urandom(),
                                          $urandom(), $urandom(), $urandom()));
      end
    end
    n_total = pending_dates.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    wait (n_dates_in == n_total && n_results_out == n_total);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d dates (%0d directed corners, rest random incl. raw field bits)",
             n_total, n_directed);
    $display("Checked %0d results with %0d mismatches", n_results_out, n_errors);
    if (n_errors == 0 && expected_secs.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
